@@ hw/rtl/deferred_handle_allocator_defines.svh @@
// Assertion macros used by the allocator back end (dha_back).
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef DEFERRED_HANDLE_ALLOCATOR_DEFINES_SVH
`define DEFERRED_HANDLE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define DHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define DHA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define DHA_ASSERT(lbl, prop)
`define DHA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/dha_pkg.sv @@
package dha_pkg;

  localparam int DHA_HANDLE_COUNT = 256;
  localparam int HANDLE_W = 8;
  localparam int MAP_SIZE = 256;
  localparam int GROUP_W = 16;
  localparam int GROUPS = MAP_SIZE / GROUP_W;
  localparam logic [HANDLE_W-1:0] LIMIT_RESET = 8'd255;

  typedef enum logic [1:0] {
    K_CREATE  = 2'd0,
    K_RELEASE = 2'd1,
    K_COMMIT  = 2'd2,
    K_NOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_LIMIT   = 2'd1,
    STS_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_LIM,
    S_REL_A,
    S_REL_D,
    S_CRE_A,
    S_CRE_D
  } state_t;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic                 bad_range;
  } cmd_t;

  // Index of the lowest set bit of a 16-bit word (0 when none is set).
  function automatic logic [3:0] lowest16(input logic [GROUP_W-1:0] w);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (w[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/deferred_handle_allocator.sv @@
// Channel  Direction  Payload
// in_      slave      tdata: handle[7:0]; tuser: op[1:0]
// out_     master     tdata: new_handle[7:0], live_count[15:8]; tuser: status[1:0]
// cfg_     slave      data: handle_limit[7:0], always ready
//
// The front registers each transfer in its command queue before the back end starts on it.
// Back end: releases and unused ops end in S_IDLE; creates end there or in S_SRCH or S_LIM.
// A commit walks each queued release, then each queued create, with one RAM read for each.
// The input side is a two-entry command queue, so items are taken while a result waits.
// Reset (rst_n low, synchronous) empties both queues, clears the maps and sets handle_limit 255.
// The back end starts a new item only when the output register is free or being taken.
module deferred_handle_allocator import dha_pkg::*; #(
  parameter int HANDLE_COUNT = DHA_HANDLE_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // handle[7:0]
  input  logic [1:0]  in_tuser,    // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // new_handle[7:0], live_count[15:8]
  output logic [1:0]  out_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data     // handle_limit[7:0]
);

  logic [HANDLE_W-1:0] limit_r, limit_nxt;
  logic                cmd_valid;
  logic                cmd_pop;
  cmd_t                cmd;

  // Limit register: takes a transfer in any cycle.
  assign cfg_ready = 1'b1;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  dha_front #(.HANDLE_COUNT(HANDLE_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  dha_back #(.HANDLE_COUNT(HANDLE_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .handle_limit(limit_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

@@ hw/rtl/dha_ram.sv @@
module dha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/dha_front.sv @@
module dha_front import dha_pkg::*; #(
  parameter int HANDLE_COUNT = DHA_HANDLE_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // handle[7:0]
  input  logic [1:0] in_tuser,   // op[1:0]
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push;

  // Classify the incoming item.
  always_comb begin
    case (in_tuser)
      K_CREATE:  dec.kind = K_CREATE;
      K_RELEASE: dec.kind = K_RELEASE;
      K_COMMIT:  dec.kind = K_COMMIT;
      default:   dec.kind = K_NOP;
    endcase
    dec.handle    = in_tdata;
    dec.bad_range = (in_tdata == '0) || (32'(in_tdata) >= HANDLE_COUNT);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rptr_r];

  // Two-entry command queue pointers.
  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ cmd_pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= dec;
    end
  end

endmodule

@@ hw/rtl/dha_back.sv @@
`include "deferred_handle_allocator_defines.svh"
module dha_back import dha_pkg::*; #(
  parameter int HANDLE_COUNT = DHA_HANDLE_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  input  logic [HANDLE_W-1:0] handle_limit,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // new_handle[7:0], live_count[15:8]
  output logic [1:0]          out_tuser   // status[1:0]
);

  localparam int AW = $clog2(HANDLE_COUNT);
  localparam int FW = $clog2(HANDLE_COUNT + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(HANDLE_COUNT);
  localparam logic [8:0] FRESH_END = (HANDLE_COUNT < MAP_SIZE) ? 9'(HANDLE_COUNT) : 9'd256;

  state_t              state_r, state_nxt;
  logic [MAP_SIZE-1:0] live_r, live_nxt;
  logic [MAP_SIZE-1:0] released_r, released_nxt;
  logic [8:0]          fresh_r, fresh_nxt;
  logic [FW-1:0]       rq_fill_r, rq_fill_nxt;
  logic [FW-1:0]       cq_fill_r, cq_fill_nxt;
  logic [FW-1:0]       idx_r, idx_nxt;
  logic [HANDLE_W-1:0] count_r, count_nxt;
  logic [3:0]          grp_r, grp_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_count_r, out_count_nxt;

  logic                rq_we, cq_we;
  logic [AW-1:0]       rq_raddr, cq_raddr, cq_waddr;
  logic [HANDLE_W-1:0] cq_wdata, rq_rdata, cq_rdata;
  logic [GROUPS-1:0]   grp_any;
  logic [GROUP_W-1:0]  word;
  logic [HANDLE_W-1:0] id;
  logic                res_we;
  logic [HANDLE_W-1:0] res_handle;
  status_t             res_status;
  logic                out_free;

  // Pending release queue and booked create queue.
  dha_ram #(.WIDTH(HANDLE_W), .DEPTH(HANDLE_COUNT)) u_rq (
    .clk(clk), .we(rq_we), .waddr(rq_fill_r[AW-1:0]), .wdata(cmd.handle),
    .raddr(rq_raddr), .rdata(rq_rdata)
  );

  dha_ram #(.WIDTH(HANDLE_W), .DEPTH(HANDLE_COUNT)) u_cq (
    .clk(clk), .we(cq_we), .waddr(cq_waddr), .wdata(cq_wdata),
    .raddr(cq_raddr), .rdata(cq_rdata)
  );

  // Per-group summary of released handles for the two-step search.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |released_r[g*GROUP_W +: GROUP_W];
    end
  end

  assign word     = released_r[{grp_r, 4'h0} +: GROUP_W];
  assign out_free = !out_valid_r || out_tready;
  assign rq_raddr = (state_r == S_REL_A) ? idx_r[AW-1:0] : '0;
  assign cq_raddr = idx_r[AW-1:0];
  assign cq_waddr = cq_fill_r[AW-1:0];

  // Sequencer: next state, map updates and result.
  always_comb begin
    state_nxt    = state_r;
    live_nxt     = live_r;
    released_nxt = released_r;
    fresh_nxt    = fresh_r;
    rq_fill_nxt  = rq_fill_r;
    cq_fill_nxt  = cq_fill_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    grp_nxt      = grp_r;
    found_nxt    = found_r;
    cmd_pop      = 1'b0;
    rq_we        = 1'b0;
    cq_we        = 1'b0;
    cq_wdata     = '0;
    res_we       = 1'b0;
    res_handle   = '0;
    res_status   = STS_OK;
    id           = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_CREATE: begin
              if (cq_fill_r >= FILL_FULL) begin
                res_we     = 1'b1;
                res_status = STS_LIMIT;
              end else if (count_r >= handle_limit) begin
                if (rq_fill_r == '0) begin
                  res_we     = 1'b1;
                  res_status = STS_LIMIT;
                end else begin
                  state_nxt = S_LIM;
                end
              end else begin
                grp_nxt   = lowest16(grp_any);
                found_nxt = |grp_any;
                state_nxt = S_SRCH;
              end
            end
            K_RELEASE: begin
              res_we = 1'b1;
              if (cmd.bad_range || !live_r[cmd.handle]) begin
                res_status = STS_INVALID;
              end else if (rq_fill_r >= FILL_FULL) begin
                res_status = STS_LIMIT;
              end else begin
                rq_we       = 1'b1;
                rq_fill_nxt = rq_fill_r + FW'(1);
              end
            end
            K_COMMIT: begin
              idx_nxt = '0;
              if (rq_fill_r != '0) begin
                state_nxt = S_REL_A;
              end else if (cq_fill_r != '0) begin
                state_nxt = S_CRE_A;
              end else begin
                res_we = 1'b1;
              end
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      S_SRCH: begin
        state_nxt = S_IDLE;
        res_we    = 1'b1;
        if (found_r) begin
          id               = {grp_r, lowest16(word)};
          released_nxt[id] = 1'b0;
        end else if (fresh_r < FRESH_END) begin
          id        = fresh_r[HANDLE_W-1:0];
          fresh_nxt = fresh_r + 9'd1;
        end
        if (found_r || (fresh_r < FRESH_END)) begin
          cq_we       = 1'b1;
          cq_wdata    = id;
          cq_fill_nxt = cq_fill_r + FW'(1);
          res_handle  = id;
        end else begin
          res_status = STS_LIMIT;
        end
      end
      S_LIM: begin
        // Reuse the handle at the front of the pending release queue.
        state_nxt   = S_IDLE;
        res_we      = 1'b1;
        cq_we       = 1'b1;
        cq_wdata    = rq_rdata;
        cq_fill_nxt = cq_fill_r + FW'(1);
        res_handle  = rq_rdata;
      end
      S_REL_A: begin
        state_nxt = S_REL_D;
      end
      S_REL_D: begin
        if (live_r[rq_rdata]) begin
          live_nxt[rq_rdata] = 1'b0;
          count_nxt          = count_r - HANDLE_W'(1);
        end
        released_nxt[rq_rdata] = 1'b1;
        idx_nxt = idx_r + FW'(1);
        if (idx_nxt == rq_fill_r) begin
          rq_fill_nxt = '0;
          idx_nxt     = '0;
          if (cq_fill_r != '0) begin
            state_nxt = S_CRE_A;
          end else begin
            state_nxt = S_IDLE;
            res_we    = 1'b1;
          end
        end else begin
          state_nxt = S_REL_A;
        end
      end
      S_CRE_A: begin
        state_nxt = S_CRE_D;
      end
      S_CRE_D: begin
        if (!live_r[cq_rdata]) begin
          live_nxt[cq_rdata] = 1'b1;
          count_nxt          = count_r + HANDLE_W'(1);
        end
        released_nxt[cq_rdata] = 1'b0;
        idx_nxt = idx_r + FW'(1);
        if (idx_nxt == cq_fill_r) begin
          cq_fill_nxt = '0;
          idx_nxt     = '0;
          state_nxt   = S_IDLE;
          res_we      = 1'b1;
        end else begin
          state_nxt = S_CRE_A;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register: load a result, or drop one once it is taken.
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (res_we) begin
      out_valid_nxt  = 1'b1;
      out_handle_nxt = res_handle;
      out_status_nxt = res_status;
      out_count_nxt  = count_nxt;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      released_r  <= '0;
      fresh_r     <= 9'd1;
      rq_fill_r   <= '0;
      cq_fill_r   <= '0;
      idx_r       <= '0;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      released_r  <= released_nxt;
      fresh_r     <= fresh_nxt;
      rq_fill_r   <= rq_fill_nxt;
      cq_fill_r   <= cq_fill_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    grp_r        <= grp_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_handle_r};
  assign out_tuser  = out_status_r;

  // A handle is never live and released at once.
  `DHA_ASSERT(a_live_released_disjoint, (live_r & released_r) == '0)
  // Handle zero is never live or released.
  `DHA_ASSERT(a_handle_zero_unused, !live_r[0] && !released_r[0])
  // Queue fills stay within capacity.
  `DHA_ASSERT(a_fill_bound, (rq_fill_r <= FILL_FULL) && (cq_fill_r <= FILL_FULL))
  // The live count moves only while a commit applies queue entries.
  `DHA_ASSERT_NEXT(a_count_only_in_commit, (state_r != S_REL_D) && (state_r != S_CRE_D), $stable(count_r))
  // A result from a multi-cycle operation always finds the output register free.
  `DHA_ASSERT(a_result_slot_free, !(res_we && (state_r != S_IDLE) && out_valid_r))

endmodule

@@ tb/tb_deferred_handle_allocator.sv @@
`timescale 1ns / 1ps

import dha_pkg::*;

// Expected fields of one result.
typedef struct {
  logic [7:0] new_handle;
  status_t    status;
  logic [7:0] live_count;
} alloc_result_t;

// Mirror of the allocator state; predicts each result and compares the DUT output.
class alloc_scoreboard;
  bit            live[256];
  bit            released[256];
  int            next_fresh;
  int            committed;
  logic [7:0]    limit;
  logic [7:0]    create_q[$];
  logic [7:0]    release_q[$];
  alloc_result_t expected_q[$];
  int            mismatches;

  function void new_state();
    foreach (live[i]) begin
      live[i] = 0;
      released[i] = 0;
    end
    next_fresh = 1;
    committed = 0;
    limit = LIMIT_RESET;
    create_q.delete();
    release_q.delete();
    expected_q.delete();
    mismatches = 0;
  endfunction

  // Booking of a handle for a create.
  function void book(ref alloc_result_t r);
    int id;
    id = 0;
    if (create_q.size() >= 256) begin
      r.status = STS_LIMIT;
      return;
    end
    if (committed >= limit) begin
      if (release_q.size() == 0) begin
        r.status = STS_LIMIT;
        return;
      end
      create_q.push_back(release_q[0]);
      r.new_handle = release_q[0];
      return;
    end
    for (int i = 1; i < 256; i++) begin
      if (released[i] && id == 0) id = i;
    end
    if (id != 0) begin
      released[id] = 0;
    end else if (next_fresh < 256) begin
      id = next_fresh;
      next_fresh++;
    end else begin
      r.status = STS_LIMIT;
      return;
    end
    create_q.push_back(8'(id));
    r.new_handle = 8'(id);
  endfunction

  // Note one accepted input transfer and queue its expected result.
  function void note_input(kind_t op, logic [7:0] h);
    alloc_result_t r;
    r.new_handle = 8'd0;
    r.status = STS_OK;
    case (op)
      K_CREATE: book(r);
      K_RELEASE: begin
        if (h == 0 || !live[h]) r.status = STS_INVALID;
        else if (release_q.size() >= 256) r.status = STS_LIMIT;
        else release_q.push_back(h);
      end
      K_COMMIT: begin
        foreach (release_q[i]) begin
          if (live[release_q[i]]) begin
            live[release_q[i]] = 0;
            committed--;
          end
          released[release_q[i]] = 1;
        end
        release_q.delete();
        foreach (create_q[i]) begin
          if (!live[create_q[i]]) begin
            live[create_q[i]] = 1;
            committed++;
          end
          released[create_q[i]] = 0;
        end
        create_q.delete();
      end
      default: ;
    endcase
    r.live_count = 8'(committed);
    expected_q.push_back(r);
  endfunction

  // Compare one accepted result transfer with the oldest expectation.
  function void check_result(logic [7:0] nh, logic [1:0] st, logic [7:0] lc);
    alloc_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: handle %0d status %0d live %0d",
                                     nh, st, lc);
      return;
    end
    e = expected_q.pop_front();
    if (nh !== e.new_handle || st !== e.status || lc !== e.live_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected handle %0d status %0d live %0d, got %0d %0d %0d",
                 e.new_handle, e.status, e.live_count, nh, st, lc);
    end
  endfunction

  // A live handle when there is one, else any handle.
  function logic [7:0] pick_live();
    int cand[$];
    for (int i = 1; i < 256; i++) if (live[i]) cand.push_back(i);
    if (cand.size() == 0) return 8'($urandom_range(255));
    return 8'(cand[$urandom_range(cand.size() - 1)]);
  endfunction
endclass

module tb_deferred_handle_allocator;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  alloc_scoreboard alloc_sb;
  int  idle_pct;
  int  stall_pct;
  bit  hold_req;
  bit  hold_taken;
  int  hold_left;

  deferred_handle_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      alloc_sb.check_result(out_tdata[7:0], out_tuser, out_tdata[15:8]);
  end

  // Offer one item, with an optional gap before it, until it is taken.
  task automatic send_item(kind_t op, logic [7:0] h);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= h;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    alloc_sb.note_input(op, h);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (alloc_sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the handle limit once the block is idle.
  task automatic write_limit(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    alloc_sb.limit = v;
  endtask

  // Random mix: mostly creates and releases of live handles, some commits and noise.
  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) send_item(K_CREATE, 8'($urandom_range(255)));
      else if (r < 70) send_item(K_RELEASE, alloc_sb.pick_live());
      else if (r < 80) send_item(K_RELEASE, 8'($urandom_range(255)));
      else if (r < 94) send_item(K_COMMIT, 8'($urandom_range(255)));
      else send_item(K_NOP, 8'($urandom_range(255)));
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 55; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 55; end
      default: begin idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  initial begin
    logic [7:0] limits[5];
    alloc_sb = new();
    alloc_sb.new_state();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = K_NOP;
    cfg_valid = 1'b0;
    cfg_data = 8'd0;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fresh handles, invalid and repeated releases, reuse of released handles.
    write_limit(8'd255);
    send_item(K_CREATE, 8'hFF);
    send_item(K_CREATE, 8'h00);
    send_item(K_CREATE, 8'hAA);
    send_item(K_RELEASE, 8'd1);
    send_item(K_COMMIT, 8'h55);
    send_item(K_RELEASE, 8'd0);
    send_item(K_RELEASE, 8'd255);
    send_item(K_RELEASE, 8'd2);
    send_item(K_RELEASE, 8'd2);
    send_item(K_NOP, 8'hFF);
    send_item(K_CREATE, 8'd0);
    send_item(K_COMMIT, 8'd0);
    send_item(K_CREATE, 8'd0);
    send_item(K_RELEASE, 8'd3);
    send_item(K_CREATE, 8'd0);
    send_item(K_COMMIT, 8'd0);
    send_item(K_CREATE, 8'd0);
    send_item(K_COMMIT, 8'd0);

    // Exhaust fresh handles.
    for (int k = 0; k < 258; k++) send_item(K_CREATE, 8'($urandom_range(255)));
    send_item(K_COMMIT, 8'd0);

    // Overflow the release queue with repeats of one live handle.
    for (int k = 0; k < 258; k++) send_item(K_RELEASE, 8'd5);
    send_item(K_COMMIT, 8'd0);

    // Limit of one: fail with nothing pending, then fill the create queue by reuse.
    write_limit(8'd1);
    send_item(K_CREATE, 8'd0);
    send_item(K_RELEASE, 8'd7);
    for (int k = 0; k < 258; k++) send_item(K_CREATE, 8'($urandom_range(255)));
    send_item(K_COMMIT, 8'd0);

    // Long receiver hold-off while the sender keeps offering items.
    write_limit(8'd255);
    hold_req = 1'b1;
    random_items(60);

    // Random phases over several limits and idling patterns.
    limits[0] = 8'd255;
    limits[1] = 8'd1;
    limits[2] = 8'($urandom_range(2, 254));
    limits[3] = 8'd10;
    limits[4] = 8'd3;
    for (int p = 0; p < 10; p++) begin
      write_limit(limits[p % 5]);
      set_idling(p);
      random_items(20);
    end

    drain();
    repeat (20) @(posedge clk);
    if (alloc_sb.mismatches == 0 && alloc_sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
